>>> rtl/core/emdt_pkg.sv
`default_nettype none
package emdt_pkg;

  localparam int unsigned CapacityDefault = 64;
  localparam int unsigned SlotW = 6;
  localparam int unsigned CoordW = 16;
  localparam int unsigned RespW = 32;
  localparam int unsigned SumW = 33;
  localparam int unsigned DistW = 24;
  localparam int unsigned EpiW = 24;
  localparam int unsigned ImgW = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] RegMatchRadius = 1'b0;
  localparam logic [CfgIdxW-1:0] RegDistEqualEps = 1'b1;

  // Epipolar thresholds in Q12.12.
  localparam logic signed [EpiW:0] EpiDupLim = 25'sd41;
  localparam logic signed [EpiW:0] EpiGateLim = -25'sd204;
  localparam logic signed [EpiW:0] EpiStrongLim = -25'sd614;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StRead,
    StDecide,
    StOut
  } state_e;

endpackage
`default_nettype wire

>>> rtl/core/emdt_ram.sv
`default_nettype none
module emdt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/core/epipolar_match_dedup_table.sv
// Each request steps through StScan and StRead for each stored entry scanned, stopping
// at the first hit or the end of the table, then through StDecide and StOut. For each
// entry StScan issues a registered memory read, then StRead does the point compare.
// Throughput: one request at a time; the next is taken once the result is sent.
// Reset (asynchronous, active low) empties the table and loads the register
// defaults; entry contents are not cleared.
`default_nettype none
module epipolar_match_dedup_table
  import emdt_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // first_x, first_y, first_response, second_x, second_y, second_response,
  // descriptor_distance, epipolar_dist, image_index
  input  wire logic [191:0]        s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // accepted, appended, slot, table_full, zero fill
  output logic [15:0]              m_axis_tdata
);

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(Capacity);
  localparam int unsigned EntW = 4 * CoordW + SumW + DistW + EpiW + ImgW;

  state_e state_q, state_d;
  logic [15:0] radius_q;
  logic [DistW-1:0] eps_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [191:0] in_q;
  logic accepted_q, accepted_d, appended_q, appended_d, full_q, full_d;
  logic [SlotW-1:0] slot_q, slot_d;

  // Unpacked request fields.
  logic [CoordW-1:0] n_fx, n_fy, n_sx, n_sy;
  logic [SumW-1:0] n_sum;
  logic [DistW-1:0] n_dist;
  logic [EpiW-1:0] n_epi;
  logic [ImgW-1:0] n_img;
  assign n_fx = in_q[15:0];
  assign n_fy = in_q[31:16];
  assign n_sx = in_q[79:64];
  assign n_sy = in_q[95:80];
  assign n_sum = {1'b0, in_q[63:32]} + {1'b0, in_q[127:96]};
  assign n_dist = in_q[151:128];
  assign n_epi = in_q[175:152];
  assign n_img = in_q[191:176];

  // Memories: second point (scanned) and the whole entry.
  logic pt_we, ent_we;
  logic [AddrW-1:0] waddr, raddr;
  logic [2*CoordW-1:0] pt_rd;
  logic [EntW-1:0] ent_rd;
  assign raddr = idx_q[AddrW-1:0];

  emdt_ram #(.Width(2 * CoordW), .Depth(Capacity)) u_pt_ram (
    .clk_i, .we_i(pt_we), .waddr_i(waddr), .wdata_i({n_sy, n_sx}),
    .raddr_i(raddr), .rdata_o(pt_rd)
  );

  emdt_ram #(.Width(EntW), .Depth(Capacity)) u_ent_ram (
    .clk_i, .we_i(ent_we), .waddr_i(waddr),
    .wdata_i({n_img, n_epi, n_dist, n_sum, n_fy, n_fx, n_sy, n_sx}),
    .raddr_i(raddr), .rdata_o(ent_rd)
  );

  logic [DistW-1:0] o_dist;
  logic [EpiW-1:0] o_epi;
  logic [SumW-1:0] o_sum;
  assign o_sum = ent_rd[4*CoordW +: SumW];
  assign o_dist = ent_rd[4*CoordW+SumW +: DistW];
  assign o_epi = ent_rd[4*CoordW+SumW+DistW +: EpiW];

  // Point compare for the entry read last cycle.
  logic [CoordW-1:0] dx, dy;
  logic hit;
  always_comb begin
    dx = (pt_rd[CoordW-1:0] > n_sx) ? pt_rd[CoordW-1:0] - n_sx : n_sx - pt_rd[CoordW-1:0];
    dy = (pt_rd[2*CoordW-1:CoordW] > n_sy) ? pt_rd[2*CoordW-1:CoordW] - n_sy
                                           : n_sy - pt_rd[2*CoordW-1:CoordW];
    hit = (dx < radius_q) && (dy < radius_q);
  end

  // Replace decision; constant multiplies are shift-add, no wide multiplier.
  logic replace;
  logic signed [EpiW:0] diff;
  logic [DistW-1:0] dd;
  logic [DistW+6:0] dn10, do11, dn23, do20, dn49, do50;
  logic [SumW+7:0] sn100, so103;
  logic [SumW+2:0] sn4, so5;
  always_comb begin
    diff = $signed({1'b0, n_epi}) - $signed({1'b0, o_epi});
    dd = (n_dist > o_dist) ? n_dist - o_dist : o_dist - n_dist;
    dn10 = (31'(n_dist) << 3) + (31'(n_dist) << 1);
    do11 = (31'(o_dist) << 3) + (31'(o_dist) << 1) + 31'(o_dist);
    dn23 = (31'(n_dist) << 4) + (31'(n_dist) << 2) + (31'(n_dist) << 1) + 31'(n_dist);
    do20 = (31'(o_dist) << 4) + (31'(o_dist) << 2);
    dn49 = (31'(n_dist) << 5) + (31'(n_dist) << 4) + 31'(n_dist);
    do50 = (31'(o_dist) << 5) + (31'(o_dist) << 4) + (31'(o_dist) << 1);
    sn100 = (41'(n_sum) << 6) + (41'(n_sum) << 5) + (41'(n_sum) << 2);
    so103 = (41'(o_sum) << 6) + (41'(o_sum) << 5) + (41'(o_sum) << 2)
          + (41'(o_sum) << 1) + 41'(o_sum);
    sn4 = 36'(n_sum) << 2;
    so5 = (36'(o_sum) << 2) + 36'(o_sum);
    priority if ((dd < eps_q) && (diff < EpiDupLim) && (diff > -EpiDupLim)) begin
      replace = 1'b0;
    end else if (!((diff < EpiGateLim) && (dn10 < do11))) begin
      replace = 1'b0;
    end else if (diff < EpiStrongLim) begin
      replace = 1'b1;
    end else if (n_dist < o_dist) begin
      replace = (dn23 < do20) || (sn100 > so103);
    end else begin
      replace = (dn49 < do50) && (sn4 > so5);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (s_axis_tvalid) state_d = StScan;
      StScan:   state_d = (idx_q >= count_q) ? StDecide : StRead;
      StRead:   state_d = hit ? StDecide : StScan;
      StDecide: state_d = StOut;
      StOut:    if (m_axis_tready) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    idx_d = idx_q;
    count_d = count_q;
    accepted_d = accepted_q;
    appended_d = appended_q;
    full_d = full_q;
    slot_d = slot_q;
    pt_we = 1'b0;
    ent_we = 1'b0;
    waddr = idx_q[AddrW-1:0];
    s_axis_tready = (state_q == StIdle);
    m_axis_tvalid = (state_q == StOut);
    unique case (state_q)
      StIdle: begin
        idx_d = '0;
      end
      StRead: begin
        if (!hit) idx_d = idx_q + 1'b1;
      end
      StScan: ;
      StDecide: begin
        accepted_d = 1'b0;
        appended_d = 1'b0;
        full_d = 1'b0;
        slot_d = SlotW'(idx_q);
        if (idx_q >= count_q) begin
          if (count_q >= CntMax) begin
            full_d = 1'b1;
            slot_d = '0;
          end else begin
            pt_we = 1'b1;
            ent_we = 1'b1;
            accepted_d = 1'b1;
            appended_d = 1'b1;
            count_d = count_q + 1'b1;
          end
        end else if (replace) begin
          pt_we = 1'b1;
          ent_we = 1'b1;
          accepted_d = 1'b1;
        end
      end
      StOut: ;
      default: ;
    endcase
  end

  assign m_axis_tdata = {7'b0, full_q, slot_q, appended_q, accepted_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      idx_q <= '0;
      radius_q <= 16'd16;
      eps_q <= 24'd1;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q <= idx_d;
      if (cfg_we_i && cfg_idx_i == RegMatchRadius) radius_q <= cfg_data_i[15:0];
      if (cfg_we_i && cfg_idx_i == RegDistEqualEps) eps_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_q <= s_axis_tdata;
    accepted_q <= accepted_d;
    appended_q <= appended_d;
    full_q <= full_d;
    slot_q <= slot_d;
  end

  ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax) else $error("entry count beyond capacity");
  ap_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && full_q |-> !accepted_q && count_q == CntMax)
    else $error("full result with room left");
  ap_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDecide && appended_d |=> count_q == $past(count_q) + 1'b1)
    else $error("append did not grow table");

endmodule
`default_nettype wire
